// ===== design/ddet_pkg.sv =====
// ----------------------------------------------------------------------------
// Deadlock detector package
// Shared constants, widths, command and state codes, and the structures that
// travel between the top level, the table store and the sequencer.
// ----------------------------------------------------------------------------
package ddet_pkg;

	// Table dimensions and the width of one stored unit count.
	localparam int NUM_PROC    = 8;
	localparam int NUM_RES     = 4;
	localparam int AMOUNT_BITS = 8;

	// Index widths and the width of the work vector, which holds the
	// available count plus every allocation without wrapping.
	localparam int PROC_W = (NUM_PROC > 1) ? $clog2(NUM_PROC) : 1;
	localparam int RES_W  = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
	localparam int CNT_W  = $clog2(NUM_PROC + 1);
	localparam int WORK_W = AMOUNT_BITS + $clog2(NUM_PROC + 1);

	// Fixed widths of the input fields.
	localparam int CMD_W  = 2;
	localparam int PIDX_W = 3;
	localparam int RIDX_W = 2;
	localparam int AMT_W  = 8;
	localparam int PID_W  = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_REQUEST = 2'd1,
		CMD_AVAIL   = 2'd2,
		CMD_RUN     = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_CHECK,
		ST_ADD,
		ST_PASS_END,
		ST_EMIT_SAFE,
		ST_EMIT_DEAD
	} state_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	// One load beat towards the table store.
	typedef struct packed {
		logic              we;
		logic [CMD_W-1:0]  cmd;
		logic [PIDX_W-1:0] proc;
		logic [RIDX_W-1:0] res;
		logic [AMT_W-1:0]  amount;
	} load_t;

	// Read address of the table store.
	typedef struct packed {
		logic [PROC_W-1:0] proc;
		logic [RES_W-1:0]  res;
	} rd_addr_t;

	// Entries read at the current address.
	typedef struct packed {
		logic [AMOUNT_BITS-1:0] alloc;
		logic [AMOUNT_BITS-1:0] request;
		logic [AMOUNT_BITS-1:0] avail;
	} rd_data_t;

endpackage

// ===== design/ddet_tables.sv =====
// ----------------------------------------------------------------------------
// Deadlock detector table store
// Holds the allocation table, the request table and the available vector.
// Load beats write one entry; one read address serves all three stores.
// ----------------------------------------------------------------------------
module ddet_tables (
	input  logic               clk,
	input  logic               arst_n,
	input  ddet_pkg::load_t    load,
	input  ddet_pkg::rd_addr_t rd_addr,
	output ddet_pkg::rd_data_t rd_data
);
	import ddet_pkg::*;

	logic [AMOUNT_BITS-1:0] alloc_q   [NUM_PROC][NUM_RES];
	logic [AMOUNT_BITS-1:0] request_q [NUM_PROC][NUM_RES];
	logic [AMOUNT_BITS-1:0] avail_q   [NUM_RES];

	logic                   proc_ok;
	logic                   res_ok;
	logic [PROC_W-1:0]      wr_proc;
	logic [RES_W-1:0]       wr_res;
	logic [AMOUNT_BITS-1:0] wr_amount;

	// Decode the write address; out of range loads are dropped.
	always_comb begin
		proc_ok   = 32'(load.proc) < NUM_PROC;
		res_ok    = 32'(load.res) < NUM_RES;
		wr_proc   = PROC_W'(load.proc);
		wr_res    = RES_W'(load.res);
		wr_amount = AMOUNT_BITS'(load.amount);
	end

	// Table writes; all entries clear at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PROC; p++) begin
				for (int r = 0; r < NUM_RES; r++) begin
					alloc_q[p][r]   <= '0;
					request_q[p][r] <= '0;
				end
			end
			for (int r = 0; r < NUM_RES; r++) begin
				avail_q[r] <= '0;
			end
		end else if (load.we && res_ok) begin
			unique case (cmd_t'(load.cmd))
				CMD_ALLOC: begin
					if (proc_ok) alloc_q[wr_proc][wr_res] <= wr_amount;
				end
				CMD_REQUEST: begin
					if (proc_ok) request_q[wr_proc][wr_res] <= wr_amount;
				end
				CMD_AVAIL: begin
					avail_q[wr_res] <= wr_amount;
				end
				default: begin
				end
			endcase
		end
	end

	// Read port at the sequencer's current process and resource.
	always_comb begin
		rd_data.alloc   = alloc_q[rd_addr.proc][rd_addr.res];
		rd_data.request = request_q[rd_addr.proc][rd_addr.res];
		rd_data.avail   = avail_q[rd_addr.res];
	end

endmodule

// ===== design/ddet_alu.sv =====
// ----------------------------------------------------------------------------
// Deadlock detector shared adder
// One adder serves both the request check (work minus request, with the
// borrow flagging a request larger than work) and the allocation release.
// ----------------------------------------------------------------------------
module ddet_alu (
	input  ddet_pkg::alu_op_t                 op,
	input  logic [ddet_pkg::WORK_W-1:0]       a,
	input  logic [ddet_pkg::AMOUNT_BITS-1:0]  b,
	output logic [ddet_pkg::WORK_W-1:0]       sum,
	output logic                              borrow
);
	import ddet_pkg::*;

	logic              sub;
	logic [WORK_W-1:0] b_ext;
	logic [WORK_W-1:0] b_opd;
	logic [WORK_W:0]   full;

	// Subtraction adds the inverted operand plus one.
	always_comb begin
		sub    = (op == ALU_SUB);
		b_ext  = WORK_W'(b);
		b_opd  = sub ? ~b_ext : b_ext;
		full   = {1'b0, a} + {1'b0, b_opd} + (WORK_W + 1)'(sub);
		sum    = full[WORK_W-1:0];
		borrow = sub & ~full[WORK_W];
	end

endmodule

// ===== design/ddet_engine.sv =====
// ----------------------------------------------------------------------------
// Deadlock detector sequencer
// Walks the processes resource by resource through the shared adder, keeps
// the work vector, finished flags and safe order, and emits the results.
// ----------------------------------------------------------------------------
module ddet_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         run,
	input  ddet_pkg::rd_data_t           rd_data,
	output ddet_pkg::rd_addr_t           rd_addr,
	output logic                         busy,
	output logic                         strobe,
	output logic [ddet_pkg::PID_W-1:0]   process_id,
	output logic                         deadlocked,
	output logic                         last
);
	import ddet_pkg::*;

	state_t            state_q, state_d;
	logic [PROC_W-1:0] proc_q;
	logic [RES_W-1:0]  res_q;
	logic [CNT_W-1:0]  order_q;
	logic [CNT_W-1:0]  emit_idx_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic              granted_q;
	logic [NUM_PROC-1:0] finished_q;
	logic [WORK_W-1:0] work_q [NUM_RES];
	logic [PROC_W-1:0] safe_q [NUM_PROC];

	logic              strobe_q;
	logic [PID_W-1:0]  pid_q;
	logic              dead_q;
	logic              last_q;

	alu_op_t           alu_op;
	logic [WORK_W-1:0] alu_sum;
	logic              alu_borrow;
	logic              res_last;
	logic              proc_last;
	logic              emit;
	logic [PROC_W-1:0] emit_pid;
	logic              emit_dead;

	// Shared adder on the current work entry.
	ddet_alu u_alu (
		.op     (alu_op),
		.a      (work_q[res_q]),
		.b      ((state_q == ST_ADD) ? rd_data.alloc : rd_data.request),
		.sum    (alu_sum),
		.borrow (alu_borrow)
	);

	assign res_last  = (32'(res_q) == NUM_RES - 1);
	assign proc_last = (32'(proc_q) == NUM_PROC - 1);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (run) state_d = ST_INIT;
			end
			ST_INIT: begin
				if (res_last) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (finished_q[proc_q] || alu_borrow) begin
					if (proc_last) state_d = ST_PASS_END;
				end else if (res_last) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (res_last) state_d = proc_last ? ST_PASS_END : ST_CHECK;
			end
			ST_PASS_END: begin
				if (granted_q && (32'(order_q) != NUM_PROC)) state_d = ST_CHECK;
				else state_d = ST_EMIT_SAFE;
			end
			ST_EMIT_SAFE: begin
				if (emit_idx_q == order_q) state_d = ST_EMIT_DEAD;
			end
			ST_EMIT_DEAD: begin
				if (proc_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: adder operation, busy and result selection.
	always_comb begin
		alu_op    = (state_q == ST_ADD) ? ALU_ADD : ALU_SUB;
		busy      = (state_q != ST_IDLE);
		emit      = 1'b0;
		emit_pid  = proc_q;
		emit_dead = 1'b0;
		unique case (state_q)
			ST_EMIT_SAFE: begin
				emit     = (emit_idx_q != order_q);
				emit_pid = safe_q[emit_idx_q[PROC_W-1:0]];
			end
			ST_EMIT_DEAD: begin
				emit      = ~finished_q[proc_q];
				emit_dead = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign rd_addr.proc = proc_q;
	assign rd_addr.res  = res_q;

	// Control registers and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			proc_q     <= '0;
			res_q      <= '0;
			order_q    <= '0;
			emit_idx_q <= '0;
			out_cnt_q  <= '0;
			granted_q  <= 1'b0;
			finished_q <= '0;
			strobe_q   <= 1'b0;
			for (int r = 0; r < NUM_RES; r++) begin
				work_q[r] <= '0;
			end
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			if (emit) out_cnt_q <= out_cnt_q + CNT_W'(1);
			unique case (state_q)
				ST_IDLE: begin
					res_q      <= '0;
					proc_q     <= '0;
					order_q    <= '0;
					granted_q  <= 1'b0;
					finished_q <= '0;
				end
				ST_INIT: begin
					work_q[res_q] <= WORK_W'(rd_data.avail);
					res_q         <= res_last ? '0 : res_q + RES_W'(1);
				end
				ST_CHECK: begin
					if (finished_q[proc_q] || alu_borrow) begin
						res_q <= '0;
						if (!proc_last) proc_q <= proc_q + PROC_W'(1);
					end else begin
						res_q <= res_last ? '0 : res_q + RES_W'(1);
					end
				end
				ST_ADD: begin
					work_q[res_q] <= alu_sum;
					if (res_last) begin
						res_q              <= '0;
						finished_q[proc_q] <= 1'b1;
						order_q            <= order_q + CNT_W'(1);
						granted_q          <= 1'b1;
						if (!proc_last) proc_q <= proc_q + PROC_W'(1);
					end else begin
						res_q <= res_q + RES_W'(1);
					end
				end
				ST_PASS_END: begin
					proc_q     <= '0;
					granted_q  <= 1'b0;
					emit_idx_q <= '0;
					out_cnt_q  <= '0;
				end
				ST_EMIT_SAFE: begin
					if (emit_idx_q != order_q) emit_idx_q <= emit_idx_q + CNT_W'(1);
				end
				ST_EMIT_DEAD: begin
					if (!proc_last) proc_q <= proc_q + PROC_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Safe order entries, written as each process is granted.
	always_ff @(posedge clk) begin
		if (state_q == ST_ADD && res_last) begin
			safe_q[order_q[PROC_W-1:0]] <= proc_q;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (emit) begin
			pid_q  <= PID_W'(emit_pid);
			dead_q <= emit_dead;
			last_q <= (32'(out_cnt_q) == NUM_PROC - 1);
		end
	end

	assign strobe     = strobe_q;
	assign process_id = pid_q;
	assign deadlocked = dead_q;
	assign last       = last_q;

endmodule

// ===== design/deadlock_detector_top.sv =====
// ----------------------------------------------------------------------------
// Deadlock detector
// Resource deadlock detection over per-process allocation and request tables.
// ----------------------------------------------------------------------------
// Usage: a command beat is taken at a rising edge with start high and busy
// low. Allocation, request and available loads write one table entry in that
// cycle, give no result and leave busy low, so loads may follow every cycle.
// A run beat raises busy while the sequencer works the process table one
// resource per cycle through a single shared adder: the available vector is
// copied into the work vector, then each pass skips a finished process,
// checks any other and releases its allocation if all its requests fit,
// and passes repeat until one grants nothing or every process is finished.
// Eight results follow, one strobe cycle each: the safe order, then the
// deadlocked processes in ascending index, the final one marked by last.
// The receiver cannot stall: each result stands for exactly one cycle.
// Reset clears every table, the work vector and the finished flags, and
// leaves the block idle.
// ----------------------------------------------------------------------------
module deadlock_detector_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [ddet_pkg::CMD_W-1:0]  command,
	input  logic [ddet_pkg::PIDX_W-1:0] process_index,
	input  logic [ddet_pkg::RIDX_W-1:0] resource_index,
	input  logic [ddet_pkg::AMT_W-1:0]  amount,
	output logic                        strobe,
	output logic [ddet_pkg::PID_W-1:0]  process_id,
	output logic                        deadlocked,
	output logic                        last
);
	import ddet_pkg::*;

	logic     accept;
	load_t    load;
	rd_addr_t rd_addr;
	rd_data_t rd_data;

	// Command beat decode.
	always_comb begin
		accept      = start & ~busy;
		load.we     = accept & (command != CMD_RUN);
		load.cmd    = command;
		load.proc   = process_index;
		load.res    = resource_index;
		load.amount = amount;
	end

	ddet_tables u_tables (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ddet_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.run        (accept & (command == CMD_RUN)),
		.rd_data    (rd_data),
		.rd_addr    (rd_addr),
		.busy       (busy),
		.strobe     (strobe),
		.process_id (process_id),
		.deadlocked (deadlocked),
		.last       (last)
	);

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Deadlock detector testbench
// Drives load and run beats into the detector. A behavioural copy of the
// allocation, request and available tables follows every accepted beat. On
// each run it works out the safe order and the deadlocked processes, and the
// monitor checks every result strobe against them in order.
// ----------------------------------------------------------------------------
module tb_top;

	import ddet_pkg::*;

	localparam int CLK_HALF    = 5;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 600;
	localparam int GAP_MAX     = 18;
	localparam int RANDOM_BEATS = 480;

	// One command beat waiting to be driven, with the idle cycles before it.
	typedef struct {
		cmd_t             cmd;
		logic [PIDX_W-1:0] pidx;
		logic [RIDX_W-1:0] ridx;
		logic [AMT_W-1:0]  amt;
		int               gap;
	} beat_t;

	// One result of a run.
	typedef struct {
		logic [PID_W-1:0] pid;
		logic             dead;
		logic             fin;
	} report_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	cmd_t                 command = CMD_ALLOC;
	logic [PIDX_W-1:0]    process_index = '0;
	logic [RIDX_W-1:0]    resource_index = '0;
	logic [AMT_W-1:0]     amount = '0;
	logic                 busy;
	logic                 strobe;
	logic [PID_W-1:0]     process_id;
	logic                 deadlocked;
	logic                 last;

	beat_t   pending_beats[$];
	report_t expected_reports[$];
	int      gap_left = 0;
	int      gap_ceiling = 0;
	int      error_count = 0;
	int      cycle_count = 0;

	// Shadow copy of the detector's tables.
	int shadow_alloc[NUM_PROC][NUM_RES];
	int shadow_request[NUM_PROC][NUM_RES];
	int shadow_avail[NUM_RES];

	deadlock_detector_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.process_index  (process_index),
		.resource_index (resource_index),
		.amount         (amount),
		.strobe         (strobe),
		.process_id     (process_id),
		.deadlocked     (deadlocked),
		.last           (last)
	);

	always #CLK_HALF clk = ~clk;

	// Safety-sequence search over the shadow tables; queues the run's reports.
	function automatic void find_safe_sequence();
		int  work[NUM_RES];
		bit  finished[NUM_PROC];
		int  order[$];
		bit  granted;
		bit  fits;
		report_t rep;
		for (int r = 0; r < NUM_RES; r++)
			work[r] = shadow_avail[r];
		for (int p = 0; p < NUM_PROC; p++)
			finished[p] = 1'b0;
		for (int pass = 0; pass < NUM_PROC; pass++) begin
			granted = 1'b0;
			for (int p = 0; p < NUM_PROC; p++) begin
				if (finished[p])
					continue;
				// Every resource must fit, not merely the first.
				fits = 1'b1;
				for (int r = 0; r < NUM_RES; r++)
					if (shadow_request[p][r] > work[r])
						fits = 1'b0;
				if (!fits)
					continue;
				for (int r = 0; r < NUM_RES; r++)
					work[r] += shadow_alloc[p][r];
				order.push_back(p);
				finished[p] = 1'b1;
				granted = 1'b1;
			end
			if (!granted)
				break;
		end
		foreach (order[i]) begin
			rep.pid  = PID_W'(order[i]);
			rep.dead = 1'b0;
			rep.fin  = 1'b0;
			expected_reports.push_back(rep);
		end
		for (int p = 0; p < NUM_PROC; p++) begin
			if (!finished[p]) begin
				rep.pid  = PID_W'(p);
				rep.dead = 1'b1;
				rep.fin  = 1'b0;
				expected_reports.push_back(rep);
			end
		end
		expected_reports[expected_reports.size() - 1].fin = 1'b1;
	endfunction

	// Applies one accepted beat to the shadow tables.
	function automatic void apply_beat(cmd_t cmd, int p, int r, int a);
		int kept;
		kept = a & ((1 << AMOUNT_BITS) - 1);
		case (cmd)
			CMD_RUN: begin
				find_safe_sequence();
			end
			CMD_AVAIL: begin
				if (r < NUM_RES)
					shadow_avail[r] = kept;
			end
			CMD_ALLOC: begin
				if (p < NUM_PROC && r < NUM_RES)
					shadow_alloc[p][r] = kept;
			end
			default: begin
				if (p < NUM_PROC && r < NUM_RES)
					shadow_request[p][r] = kept;
			end
		endcase
	endfunction

	// Adds a beat to the stimulus, with an idle gap drawn from the current ceiling.
	task automatic queue_beat(cmd_t cmd, int p, int r, int a);
		beat_t b;
		b.cmd  = cmd;
		b.pidx = PIDX_W'(p);
		b.ridx = RIDX_W'(r);
		b.amt  = AMT_W'(a);
		b.gap  = (gap_ceiling == 0) ? 0 : $urandom_range(gap_ceiling, 0);
		pending_beats.push_back(b);
	endtask

	// Amount for a random load: mostly small so that runs form chains.
	function automatic int draw_amount();
		int pick;
		pick = $urandom_range(9, 0);
		if (pick <= 5)
			return $urandom_range(3, 0);
		else if (pick == 6)
			return 0;
		else if (pick == 7)
			return (1 << AMT_W) - 1;
		else
			return $urandom_range((1 << AMT_W) - 1, 0);
	endfunction

	// Beat driver: holds each beat until it is taken, then idles for the next beat's gap.
	always @(posedge clk or negedge arst_n) begin
		beat_t b;
		if (!arst_n) begin
			start          <= 1'b0;
			command        <= CMD_ALLOC;
			process_index  <= '0;
			resource_index <= '0;
			amount         <= '0;
			gap_left       <= 0;
		end else begin
			if (start && !busy)
				apply_beat(command, int'(process_index), int'(resource_index),
					int'(amount));
			if (!start || !busy) begin
				if (gap_left > 0) begin
					start    <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_beats.size() > 0) begin
					b = pending_beats.pop_front();
					start          <= 1'b1;
					command        <= b.cmd;
					process_index  <= b.pidx;
					resource_index <= b.ridx;
					amount         <= b.amt;
					gap_left       <= (pending_beats.size() > 0) ? pending_beats[0].gap : 0;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Result monitor: each strobe is compared with the oldest expected report.
	always @(posedge clk) begin
		report_t want;
		if (arst_n && strobe === 1'b1) begin
			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected result: process_id %0d deadlocked %0b last %0b",
					$time, process_id, deadlocked, last);
				error_count++;
			end else begin
				want = expected_reports.pop_front();
				if (process_id !== want.pid) begin
					$display("%0t: process_id mismatch: expected %0d, actual %0d",
						$time, want.pid, process_id);
					error_count++;
				end
				if (deadlocked !== want.dead) begin
					$display("%0t: deadlocked mismatch: expected %0b, actual %0b",
						$time, want.dead, deadlocked);
					error_count++;
				end
				if (last !== want.fin) begin
					$display("%0t: last mismatch: expected %0b, actual %0b",
						$time, want.fin, last);
					error_count++;
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int loads;
		int made;
		for (int p = 0; p < NUM_PROC; p++)
			for (int r = 0; r < NUM_RES; r++) begin
				shadow_alloc[p][r]   = 0;
				shadow_request[p][r] = 0;
			end
		for (int r = 0; r < NUM_RES; r++)
			shadow_avail[r] = 0;

		// Directed part: empty tables, extremes, a partial fit and a real deadlock.
		gap_ceiling = 0;
		queue_beat(CMD_RUN, 5, 2, 8'hAA);
		queue_beat(CMD_REQUEST, 7, 3, 255);
		queue_beat(CMD_RUN, 0, 0, 0);
		gap_ceiling = GAP_MAX;
		queue_beat(CMD_REQUEST, 2, 1, 5);
		queue_beat(CMD_ALLOC, 5, 1, 5);
		queue_beat(CMD_ALLOC, 6, 3, 255);
		queue_beat(CMD_RUN, 7, 3, 255);
		// First resource fits while the second does not.
		queue_beat(CMD_REQUEST, 0, 0, 255);
		queue_beat(CMD_REQUEST, 0, 1, 1);
		queue_beat(CMD_AVAIL, 6, 0, 255);
		queue_beat(CMD_RUN, 2, 1, 17);
		// Process 1 waits on a unit that only the stuck process 0 holds.
		gap_ceiling = 0;
		queue_beat(CMD_AVAIL, 3, 0, 0);
		queue_beat(CMD_REQUEST, 1, 0, 1);
		queue_beat(CMD_ALLOC, 0, 0, 1);
		queue_beat(CMD_RUN, 0, 0, 0);
		queue_beat(CMD_ALLOC, 7, 3, 0);
		queue_beat(CMD_AVAIL, 7, 3, 0);
		queue_beat(CMD_RUN, 4, 1, 1);
		queue_beat(CMD_RUN, 3, 2, 254);

		// Random part: load bursts of random content, each closed by a run.
		made = 0;
		while (made < RANDOM_BEATS) begin
			gap_ceiling = ($urandom_range(1, 0) == 0) ? 0 : GAP_MAX;
			loads = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 16)
			                                    : $urandom_range(14, 2);
			for (int i = 0; i < loads; i++)
				queue_beat(cmd_t'($urandom_range(2, 0)), $urandom_range(NUM_PROC - 1, 0),
					$urandom_range(NUM_RES - 1, 0), draw_amount());
			queue_beat(CMD_RUN, $urandom_range(NUM_PROC - 1, 0), $urandom_range(NUM_RES - 1, 0),
				$urandom_range((1 << AMT_W) - 1, 0));
			if ($urandom_range(5, 0) == 0) begin
				queue_beat(CMD_RUN, $urandom_range(NUM_PROC - 1, 0),
					$urandom_range(NUM_RES - 1, 0), $urandom_range((1 << AMT_W) - 1, 0));
				made++;
			end
			made += loads + 1;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every beat to be taken and every report to arrive.
		while (pending_beats.size() > 0 || start || expected_reports.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
